// File: rtl/segment_access_check_unit_macros.svh
// Assertion macros for the segment access check unit.
// Used by the port checker; expects clk and arst_n in the using scope.
`ifndef SEGMENT_ACCESS_CHECK_UNIT_MACROS_SVH
`define SEGMENT_ACCESS_CHECK_UNIT_MACROS_SVH

// same-cycle implication, quiet during reset
`define SAC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("segment access check: property failed");

// next-cycle implication, quiet during reset
`define SAC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("segment access check: property failed");

`endif

// File: rtl/sac_pkg.sv
// Package for the segment access check unit: codes, constants and types.
// No dependencies; used by the interfaces, the check logic and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sac_pkg;

	localparam int OP_W     = 2;
	localparam int OFFSET_W = 32;
	localparam int LEN_W    = 10;
	localparam int REASON_W = 3;
	localparam int TYPE_W   = 4;
	localparam int LIMIT_W  = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [OP_W-1:0] OP_READ  = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
	localparam logic [OP_W-1:0] OP_EXEC  = 2'd2;

	localparam logic [REASON_W-1:0] RSN_NONE        = 3'd0;
	localparam logic [REASON_W-1:0] RSN_NOT_VALID   = 3'd1;
	localparam logic [REASON_W-1:0] RSN_NOT_PRESENT = 3'd2;
	localparam logic [REASON_W-1:0] RSN_TYPE        = 3'd3;
	localparam logic [REASON_W-1:0] RSN_LIMIT       = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_SEG_VALID   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEG_PRESENT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEG_TYPE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SEG_LIMIT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BIG_FLAG    = 3'd4;

	localparam logic [LIMIT_W-1:0] UPPER_BIG      = 32'hffff_ffff;
	localparam logic [LIMIT_W-1:0] UPPER_SMALL    = 32'h0000_ffff;
	localparam logic [LIMIT_W-1:0] MARK_MIN_LIMIT = 32'd31;

	typedef struct packed {
		logic               seg_valid;
		logic               seg_present;
		logic [TYPE_W-1:0]  seg_type;
		logic [LIMIT_W-1:0] seg_limit;
		logic               big_flag;
	} desc_t;

	typedef struct packed {
		logic [OP_W-1:0]     op;
		logic [OFFSET_W-1:0] offset;
		logic [LEN_W-1:0]    access_length;
	} item_t;

	typedef struct packed {
		logic read_mark;
		logic write_mark;
	} marks_t;

	typedef struct packed {
		logic                ok;
		logic [REASON_W-1:0] fault_reason;
		logic                read_ok_mark;
		logic                write_ok_mark;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/sac_if.sv
// Valid/ready channel interfaces for the segment access check unit.
// Depends on sac_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface sac_req_if;
	import sac_pkg::*;

	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     op;
	logic [OFFSET_W-1:0] offset;
	logic [LEN_W-1:0]    access_length;

	modport source (output valid, op, offset, access_length, input ready);
	modport sink (input valid, op, offset, access_length, output ready);
endinterface

interface sac_rsp_if;
	import sac_pkg::*;

	logic                valid;
	logic                ready;
	logic                ok;
	logic [REASON_W-1:0] fault_reason;
	logic                read_ok_mark;
	logic                write_ok_mark;

	modport source (output valid, ok, fault_reason, read_ok_mark, write_ok_mark, input ready);
	modport sink (input valid, ok, fault_reason, read_ok_mark, write_ok_mark, output ready);
endinterface

`default_nettype wire

// File: rtl/sac_check.sv
// Combinational check of one access against the cached descriptor.
// Gives the result word and the next sticky marks. Depends on sac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sac_check (
	input  sac_pkg::desc_t   desc,
	input  sac_pkg::item_t   item,
	input  sac_pkg::marks_t  marks,
	output sac_pkg::result_t result,
	output sac_pkg::marks_t  marks_next
);
	import sac_pkg::*;

	logic [LEN_W-1:0]   n_short;
	logic [LIMIT_W-1:0] n;
	logic [LIMIT_W-1:0] upper;
	logic               down;
	logic               code_xo;
	logic               wr_allowed;
	logic               normal_fits;
	logic               down_fits;
	logic               fits;
	logic [REASON_W-1:0] reason;

	// zero length counts as one byte
	assign n_short = (item.access_length == '0) ? '0 : item.access_length - LEN_W'(1);
	assign n       = LIMIT_W'(n_short);

	// types 4..7 expand down; 8, 9, 12, 13 are execute-only code
	assign down       = (desc.seg_type[3:2] == 2'b01);
	assign code_xo    = desc.seg_type[3] & ~desc.seg_type[1];
	assign wr_allowed = ~desc.seg_type[3] & desc.seg_type[1];

	assign upper = desc.big_flag ? UPPER_BIG : UPPER_SMALL;

	assign normal_fits = (n <= desc.seg_limit) && (item.offset <= desc.seg_limit - n);
	assign down_fits   = (item.offset > desc.seg_limit) && (item.offset <= upper)
		&& (upper - item.offset >= n);
	assign fits = down ? down_fits : normal_fits;

	always_comb begin
		reason     = RSN_NONE;
		marks_next = marks;
		priority if (!desc.seg_valid) begin
			reason = RSN_NOT_VALID;
		end else if (!desc.seg_present) begin
			reason = RSN_NOT_PRESENT;
		end else if (item.op != OP_READ && item.op != OP_WRITE && item.op != OP_EXEC) begin
			reason = RSN_TYPE;
		end else if (item.op == OP_WRITE && !wr_allowed) begin
			reason = RSN_TYPE;
		end else if (item.op == OP_READ && code_xo) begin
			reason = RSN_TYPE;
		end else if (!fits) begin
			reason = RSN_LIMIT;
		end else if (!down && desc.seg_limit >= MARK_MIN_LIMIT) begin
			if (item.op == OP_WRITE) begin
				marks_next.read_mark  = 1'b1;
				marks_next.write_mark = 1'b1;
			end else if (item.op == OP_READ || !code_xo) begin
				marks_next.read_mark = 1'b1;
			end
		end
	end

	assign result.ok            = (reason == RSN_NONE);
	assign result.fault_reason  = reason;
	assign result.read_ok_mark  = marks_next.read_mark;
	assign result.write_ok_mark = marks_next.write_mark;

endmodule

`default_nettype wire

// File: rtl/segment_access_check_unit.sv
// Segment access check unit: top level with descriptor registers and pipeline.
// Depends on sac_pkg, sac_if and sac_check.
//
// Usage:
//  - The descriptor (valid, present, type, limit, big) is loaded through the
//    write port cfg_we / cfg_index / cfg_data; index is the register number.
//    Any write to a listed register also clears the read and write marks.
//    Write it only while no word is in flight.
//  - req carries one access per word (op, offset, access_length); rsp returns
//    one result word per access (ok, fault_reason and the marks after it).
//  - An access taken on req passes through the input register, then the
//    result register, whose output drives rsp.
//  - Throughput: one access per cycle while rsp does not stall; the check is a
//    single pass of limit compares between the two registers.
//  - When rsp stalls, the result register holds and the input register still
//    takes one more word; req.ready drops only once both are full.
//  - Reset clears the descriptor, the marks and both valid flags.
`timescale 1ns / 1ps
`default_nettype none

module segment_access_check_unit (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire [sac_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [sac_pkg::CFG_DATA_W-1:0]      cfg_data,
	sac_req_if.sink                            req,
	sac_rsp_if.source                          rsp
);
	import sac_pkg::*;

	desc_t   desc_q;
	marks_t  marks_q;
	marks_t  marks_next;
	item_t   item_s1;
	logic    valid_s1;
	result_t result;
	result_t result_s2;
	logic    valid_s2;
	logic    advance;
	logic    take;

	// the result register frees up when empty or being drained
	assign advance   = ~valid_s2 | rsp.ready;
	assign req.ready = ~valid_s1 | advance;
	assign take      = req.valid & req.ready;

	sac_check u_sac_check (
		.desc       (desc_q),
		.item       (item_s1),
		.marks      (marks_q),
		.result     (result),
		.marks_next (marks_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_q   <= '0;
			marks_q  <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SEG_VALID: begin
						desc_q.seg_valid <= cfg_data[0];
						marks_q          <= '0;
					end
					REG_SEG_PRESENT: begin
						desc_q.seg_present <= cfg_data[0];
						marks_q            <= '0;
					end
					REG_SEG_TYPE: begin
						desc_q.seg_type <= cfg_data[TYPE_W-1:0];
						marks_q         <= '0;
					end
					REG_SEG_LIMIT: begin
						desc_q.seg_limit <= cfg_data[LIMIT_W-1:0];
						marks_q          <= '0;
					end
					REG_BIG_FLAG: begin
						desc_q.big_flag <= cfg_data[0];
						marks_q         <= '0;
					end
					default: begin
						// unlisted index: ignore
					end
				endcase
			end else if (advance && valid_s1) begin
				marks_q <= marks_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.op            <= req.op;
			item_s1.offset        <= req.offset;
			item_s1.access_length <= req.access_length;
		end
		if (advance && valid_s1) begin
			result_s2 <= result;
		end
	end

	assign rsp.valid         = valid_s2;
	assign rsp.ok            = result_s2.ok;
	assign rsp.fault_reason  = result_s2.fault_reason;
	assign rsp.read_ok_mark  = result_s2.read_ok_mark;
	assign rsp.write_ok_mark = result_s2.write_ok_mark;

endmodule

`default_nettype wire

// File: rtl/sac_checker.sv
// Port checker for the segment access check unit, bound to the top level.
// Depends on sac_pkg and segment_access_check_unit_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "segment_access_check_unit_macros.svh"

module sac_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          req_ready,
	input wire                          rsp_valid,
	input wire                          rsp_ready,
	input wire                          rsp_ok,
	input wire [sac_pkg::REASON_W-1:0]  rsp_fault_reason,
	input wire                          rsp_read_ok_mark,
	input wire                          rsp_write_ok_mark
);
	import sac_pkg::*;

	// pass flag and reason code must agree
	`SAC_ASSERT_IMPL(a_ok_reason, rsp_valid, rsp_ok == (rsp_fault_reason == RSN_NONE))

	// a write mark is only ever set together with the read mark
	`SAC_ASSERT_IMPL(a_mark_order, rsp_valid && rsp_write_ok_mark, rsp_read_ok_mark)

	// the reason is always one of the defined codes
	`SAC_ASSERT_IMPL(a_reason_range, rsp_valid,
		rsp_fault_reason == RSN_NONE || rsp_fault_reason == RSN_NOT_VALID ||
		rsp_fault_reason == RSN_NOT_PRESENT || rsp_fault_reason == RSN_TYPE ||
		rsp_fault_reason == RSN_LIMIT)

	// a stalled result word holds
	`SAC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
		rsp_valid && $stable(rsp_fault_reason) && $stable(rsp_read_ok_mark))

	// with no result waiting the input side is open
	`SAC_ASSERT_IMPL(a_req_open, !rsp_valid, req_ready)

endmodule

bind segment_access_check_unit sac_checker u_sac_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_ok            (rsp.ok),
	.rsp_fault_reason  (rsp.fault_reason),
	.rsp_read_ok_mark  (rsp.read_ok_mark),
	.rsp_write_ok_mark (rsp.write_ok_mark)
);

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for segment_access_check_unit: random and directed accesses
// against a local descriptor model. Depends on sac_pkg, sac_if and the unit itself.

module tb_top;
	import sac_pkg::*;

	localparam logic [OP_W-1:0]      OP_UNDEF         = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_BIG_FLAG + 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED  = '1;
	// descriptor type bits
	localparam int TYPE_CODE = 3;
	localparam int TYPE_DOWN = 2;
	localparam int TYPE_RW   = 1;
	localparam int STALL_LIMIT = 2000;

	class access_scoreboard;
		desc_t   seg;
		marks_t  marks;
		result_t pending_results[$];
		int      errors;

		function new();
			seg = '0;
			marks = '0;
			errors = 0;
		endfunction

		task report_mismatch(input string what);
			$display("mismatch at %0t: %s", $realtime, what);
			errors++;
		endtask

		function void write_reg(input logic [CFG_IDX_W-1:0] idx,
				input logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_SEG_VALID:   seg.seg_valid   = data[0];
				REG_SEG_PRESENT: seg.seg_present = data[0];
				REG_SEG_TYPE:    seg.seg_type    = data[TYPE_W-1:0];
				REG_SEG_LIMIT:   seg.seg_limit   = data[LIMIT_W-1:0];
				REG_BIG_FLAG:    seg.big_flag    = data[0];
				default: return;
			endcase
			marks = '0;
		endfunction

		function result_t predict_check(input item_t a);
			logic [LIMIT_W-1:0] n;
			logic [LIMIT_W-1:0] upper;
			logic               down;
			logic               exec_only;
			logic               writable;
			logic               fits;
			result_t            r;
			n = LIMIT_W'(a.access_length);
			if (n != 0)
				n = n - 1;
			down      = !seg.seg_type[TYPE_CODE] && seg.seg_type[TYPE_DOWN];
			exec_only = seg.seg_type[TYPE_CODE] && !seg.seg_type[TYPE_RW];
			writable  = !seg.seg_type[TYPE_CODE] && seg.seg_type[TYPE_RW];
			r.fault_reason = RSN_NONE;
			if (!seg.seg_valid)
				r.fault_reason = RSN_NOT_VALID;
			else if (!seg.seg_present)
				r.fault_reason = RSN_NOT_PRESENT;
			else if (a.op == OP_UNDEF)
				r.fault_reason = RSN_TYPE;
			else if (a.op == OP_WRITE && !writable)
				r.fault_reason = RSN_TYPE;
			else if (a.op == OP_READ && exec_only)
				r.fault_reason = RSN_TYPE;
			else begin
				if (down) begin
					upper = seg.big_flag ? UPPER_BIG : UPPER_SMALL;
					fits = a.offset > seg.seg_limit && a.offset <= upper
						&& (upper - a.offset) >= n;
				end else
					fits = n <= seg.seg_limit && a.offset <= seg.seg_limit - n;
				if (!fits)
					r.fault_reason = RSN_LIMIT;
				else if (!down && seg.seg_limit >= MARK_MIN_LIMIT) begin
					if (a.op == OP_WRITE) begin
						marks.read_mark = 1'b1;
						marks.write_mark = 1'b1;
					end else if (a.op == OP_READ || !exec_only)
						marks.read_mark = 1'b1;
				end
			end
			r.ok = (r.fault_reason == RSN_NONE);
			r.read_ok_mark = marks.read_mark;
			r.write_ok_mark = marks.write_mark;
			return r;
		endfunction

		function void note_access(input item_t a);
			pending_results.push_back(predict_check(a));
		endfunction

		task check_result(input result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result ok=%0b reason=%0d",
					got.ok, got.fault_reason));
				return;
			end
			want = pending_results.pop_front();
			if (got.ok !== want.ok)
				report_mismatch($sformatf("ok got %b want %b", got.ok, want.ok));
			if (got.fault_reason !== want.fault_reason)
				report_mismatch($sformatf("fault_reason got %0d want %0d",
					got.fault_reason, want.fault_reason));
			if (got.read_ok_mark !== want.read_ok_mark)
				report_mismatch($sformatf("read_ok_mark got %b want %b",
					got.read_ok_mark, want.read_ok_mark));
			if (got.write_ok_mark !== want.write_ok_mark)
				report_mismatch($sformatf("write_ok_mark got %b want %b",
					got.write_ok_mark, want.write_ok_mark));
		endtask

		function int pending();
			return pending_results.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	bit                    no_gaps;
	int                    quiet_cycles;
	access_scoreboard      sb;

	sac_req_if req_ch();
	sac_rsp_if rsp_ch();

	segment_access_check_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// note accepted words before checking results so a short path cannot race
	always @(posedge clk) begin
		item_t   seen;
		result_t got;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				seen.op = req_ch.op;
				seen.offset = req_ch.offset;
				seen.access_length = req_ch.access_length;
				sb.note_access(seen);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.ok = rsp_ch.ok;
				got.fault_reason = rsp_ch.fault_reason;
				got.read_ok_mark = rsp_ch.read_ok_mark;
				got.write_ok_mark = rsp_ch.write_ok_mark;
				sb.check_result(got);
			end
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb_top: errors");
				$finish;
			end
			rsp_ch.ready <= no_gaps || ($urandom_range(0, 99) >= 38);
		end
	end

	task automatic send_access(input logic [OP_W-1:0] op, input logic [OFFSET_W-1:0] off,
			input logic [LEN_W-1:0] len);
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.offset <= off;
		req_ch.access_length <= len;
		do
			@(posedge clk);
		while (!(req_ch.valid && req_ch.ready));
		if (!no_gaps && $urandom_range(0, 99) < 38) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// hold the sender until every word in flight has come back
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic drive_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.write_reg(idx, data);
		@(posedge clk);
	endtask

	task automatic write_single(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		wait_drained();
		drive_reg(idx, data);
		cfg_we <= 1'b0;
	endtask

	// noisy fills the unused upper bits of each register word with junk
	task automatic load_descriptor(input desc_t d, input bit noisy);
		logic [CFG_DATA_W-1:0] w;
		wait_drained();
		w = noisy ? $urandom : '0;
		w[0] = d.seg_valid;
		drive_reg(REG_SEG_VALID, w);
		w = noisy ? $urandom : '0;
		w[0] = d.seg_present;
		drive_reg(REG_SEG_PRESENT, w);
		w = noisy ? $urandom : '0;
		w[TYPE_W-1:0] = d.seg_type;
		drive_reg(REG_SEG_TYPE, w);
		drive_reg(REG_SEG_LIMIT, d.seg_limit);
		w = noisy ? $urandom : '0;
		w[0] = d.big_flag;
		drive_reg(REG_BIG_FLAG, w);
		cfg_we <= 1'b0;
	endtask

	function automatic desc_t make_desc(input logic v, input logic p, input logic [3:0] t,
			input logic [31:0] lim, input logic big);
		desc_t d;
		d.seg_valid = v;
		d.seg_present = p;
		d.seg_type = t;
		d.seg_limit = lim;
		d.big_flag = big;
		return d;
	endfunction

	function automatic logic [LIMIT_W-1:0] pick_limit();
		case ($urandom_range(0, 8))
			0: return '0;
			1: return MARK_MIN_LIMIT - 1;
			2: return MARK_MIN_LIMIT;
			3: return MARK_MIN_LIMIT + 1;
			4: return UPPER_SMALL;
			5: return UPPER_BIG;
			6: return $urandom_range(0, 32'h1ffff);
			7: return UPPER_SMALL - $urandom_range(0, 600);
			default: return $urandom;
		endcase
	endfunction

	function automatic desc_t random_desc();
		return make_desc($urandom_range(0, 19) != 0, $urandom_range(0, 19) != 0,
			TYPE_W'($urandom_range(0, 15)), pick_limit(), 1'($urandom_range(0, 1)));
	endfunction

	// aim offsets at the edges of whichever limit test the descriptor uses
	function automatic item_t pick_access();
		item_t              a;
		logic [LIMIT_W-1:0] n;
		logic [LIMIT_W-1:0] upper;
		logic [LIMIT_W-1:0] d;
		int                 r;
		r = $urandom_range(0, 99);
		a.op = r < 35 ? OP_READ : r < 65 ? OP_WRITE : r < 95 ? OP_EXEC : OP_UNDEF;
		r = $urandom_range(0, 99);
		if (r < 4)
			a.access_length = '0;
		else if (r < 9)
			a.access_length = LEN_W'($urandom_range(513, 1023));
		else if (r < 17)
			a.access_length = 10'd512;
		else if (r < 27)
			a.access_length = 10'd1;
		else if (r < 65)
			a.access_length = LEN_W'($urandom_range(1, 64));
		else
			a.access_length = LEN_W'($urandom_range(1, 512));
		n = LIMIT_W'(a.access_length);
		if (n != 0)
			n = n - 1;
		upper = sb.seg.big_flag ? UPPER_BIG : UPPER_SMALL;
		d = $urandom_range(0, 6);
		r = $urandom_range(0, 99);
		if (r < 30)
			a.offset = sb.seg.seg_limit - n + d - 3;
		else if (r < 50)
			a.offset = sb.seg.seg_limit + d - 3;
		else if (r < 65)
			a.offset = upper - n + d - 3;
		else if (r < 75)
			a.offset = d;
		else
			a.offset = $urandom;
		return a;
	endfunction

	task automatic directed_part();
		// reset descriptor is not valid
		send_access(OP_READ, 32'h0, 10'd1);
		load_descriptor(make_desc(1'b1, 1'b0, 4'd2, UPPER_BIG, 1'b0), 1'b0);
		send_access(OP_WRITE, 32'h0, 10'd1);
		// read-only data segment spanning 4G
		load_descriptor(make_desc(1'b1, 1'b1, 4'd0, UPPER_BIG, 1'b0), 1'b0);
		send_access(OP_WRITE, 32'h0, 10'd1);
		send_access(OP_READ, 32'h0, 10'd512);
		send_access(OP_UNDEF, 32'h0, 10'd1);
		send_access(OP_EXEC, 32'hffff_ffff, 10'd1);
		send_access(OP_READ, 32'hffff_fe00, 10'd512);
		send_access(OP_READ, 32'hffff_fe01, 10'd512);
		send_access(OP_READ, 32'hffff_ffff, 10'd0);
		// writable, limit just below the mark threshold
		load_descriptor(make_desc(1'b1, 1'b1, 4'd3, MARK_MIN_LIMIT - 1, 1'b0), 1'b1);
		send_access(OP_WRITE, 32'h0, 10'd31);
		send_access(OP_WRITE, 32'd31, 10'd1);
		send_access(OP_WRITE, 32'h0, 10'd32);
		load_descriptor(make_desc(1'b1, 1'b1, 4'd2, MARK_MIN_LIMIT, 1'b0), 1'b0);
		send_access(OP_WRITE, 32'h0, 10'd1);
		// a write to an unlisted index keeps the marks
		write_single(REG_FIRST_UNUSED, 32'hffff_ffff);
		send_access(OP_READ, 32'd31, 10'd1);
		// execute-only code
		load_descriptor(make_desc(1'b1, 1'b1, 4'd8, UPPER_SMALL, 1'b0), 1'b0);
		send_access(OP_READ, 32'h0, 10'd1);
		send_access(OP_EXEC, 32'h0, 10'd1);
		// expand-down with 64K upper bound
		load_descriptor(make_desc(1'b1, 1'b1, 4'd6, 32'h0fff, 1'b0), 1'b0);
		send_access(OP_WRITE, 32'h1000, 10'd1);
		send_access(OP_WRITE, 32'h0fff, 10'd1);
		send_access(OP_WRITE, 32'hffff, 10'd2);
		send_access(OP_READ, 32'h1_0000, 10'd1);
		// expand-down with 4G upper bound
		load_descriptor(make_desc(1'b1, 1'b1, 4'd4, 32'h0, 1'b1), 1'b0);
		send_access(OP_READ, 32'hffff_fc01, 10'd1023);
		send_access(OP_READ, 32'hffff_fc00, 10'd1023);
	endtask

	initial begin
		int                    count;
		int                    r;
		item_t                 a;
		logic [CFG_IDX_W-1:0]  idx;
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		no_gaps = 1'b0;
		quiet_cycles = 0;
		req_ch.valid = 1'b0;
		req_ch.op = OP_READ;
		req_ch.offset = '0;
		req_ch.access_length = '0;
		rsp_ch.ready = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_part();

		for (int ph = 0; ph < 30; ph++) begin
			no_gaps = (ph >= 12 && ph < 15);
			r = $urandom_range(0, 9);
			if (r < 7 || ph == 0)
				load_descriptor(random_desc(), $urandom_range(0, 1));
			else if (r < 9) begin
				idx = CFG_IDX_W'($urandom_range(REG_SEG_VALID, REG_BIG_FLAG));
				write_single(idx, $urandom);
			end else begin
				idx = CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED));
				write_single(idx, $urandom);
			end
			count = $urandom_range(50, 70);
			for (int i = 0; i < count; i++) begin
				if (ph % 7 == 3 && i == count / 2)
					wait_drained();
				a = pick_access();
				send_access(a.op, a.offset, a.access_length);
			end
		end
		no_gaps = 1'b0;

		wait_drained();
		repeat (4) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
